// ===== rtl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the purge candidate selector.
// ----------------------------------------------------------------------------
`default_nettype none
package pcs_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned HandleW = 32;
  localparam int unsigned BlocksW = 40;
  localparam int unsigned CountW  = 48;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [0:0] RegBlocksRequired = 1'b0;
  localparam logic [0:0] RegMinAccessTime  = 1'b1;

  // One table entry.
  typedef struct packed {
    logic [TimeW-1:0]   etime;
    logic [BlocksW-1:0] blocks;
    logic [HandleW-1:0] handle;
  } entry_t;

  // Saturating accumulate of a block count into a 48-bit total.
  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [BlocksW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {{(CountW - BlocksW + 1){1'b0}}, b};
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/purge_candidate_selector_core.sv =====
// ----------------------------------------------------------------------------
// purge_candidate_selector_core
// Oldest-first eviction candidate selection, one table step per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tdata: file_handle, access_time, block_count; tuser: kind
// m_axis   out        tdata: entry_valid .. total_blocks, overflow; tlast: last
// cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// A check transaction reads the newest entry and decides. An insert then
// searches one entry a cycle, shifts one entry a cycle, waits in a fetch state
// for the newest entry to be read and trims one entry a cycle. A cold check
// ends at acceptance; a skipped check ends after the decision. A drain emits
// one result per cycle while the receiver takes them, stepping through the
// zero-time entries, the cold list and the remaining entries in turn.
// Reset clears the counts and flags; the
// tables are never read above their count, so they need no clearing pass.
// The input is not ready while an item is at work or a result waits.
`default_nettype none
module purge_candidate_selector_core
  import pcs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned COLD_DEPTH  = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [47:0]   cfg_data_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] file_handle, [63:32] access_time, [103:64] block_count
  input  wire logic [103:0]  s_axis_tdata,
  // [0] kind
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [0] entry_valid, [32:1] entry_handle, [64:33] entry_time,
  // [104:65] entry_blocks, [105] is_cold, [153:106] accumulated_blocks,
  // [201:154] total_blocks, [202] overflow, [207:203] zero
  output logic [207:0]       m_axis_tdata,
  output logic               m_axis_tlast
);

  localparam int unsigned TIdxW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SCntW = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned CIdxW = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;
  localparam int unsigned CCntW = $clog2(COLD_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEARCH, S_SHIFT, S_FETCH, S_TRIM,
    S_DR_ZERO, S_DR_COLD, S_DR_REST
  } state_e;

  state_e state_q;
  logic [CountW-1:0] req_q, acc_q, tot_q;
  logic [TimeW-1:0]  mat_q;
  logic              ovf_q;
  logic [SCntW-1:0]  scnt_q, ptr_q, pos_q;
  logic [CCntW-1:0]  ccnt_q, cptr_q;
  entry_t            new_q;
  logic              emitted_q;

  // Sorted table holds one spare slot for the over-full case.
  entry_t tab_q [TABLE_DEPTH+1];
  logic [BlocksW-1:0] cb_q [COLD_DEPTH];
  logic [HandleW-1:0] ch_q [COLD_DEPTH];

  // Registered read port of the table; rd_q holds the entry addressed last cycle.
  entry_t            rd_q;
  logic [TIdxW-1:0]  raddr;
  logic [CountW-1:0] rd_blk;
  logic              search_go, trim_go, emit;

  logic [TimeW-1:0]   in_t;
  logic [BlocksW-1:0] in_b;
  assign in_t = s_axis_tdata[63:32];
  assign in_b = s_axis_tdata[103:64];

  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign rd_blk    = {{(CountW-BlocksW){1'b0}}, rd_q.blocks};
  assign search_go = (ptr_q < scnt_q) && (rd_q.etime <= new_q.etime);
  assign trim_go   = (ptr_q != '0) && (acc_q >= rd_blk) && ((acc_q - rd_blk) >= req_q);

  // Each state addresses the entry that it needs in the following cycle.
  always_comb begin
    emit  = 1'b0;
    raddr = ptr_q[TIdxW-1:0];
    unique case (state_q)
      S_IDLE:   raddr = s_axis_tuser ? '0 : TIdxW'(scnt_q - 1'b1);
      S_CHECK:  raddr = '0;
      S_SEARCH: raddr = search_go ? TIdxW'(ptr_q + 1'b1) : TIdxW'(scnt_q - 1'b1);
      S_SHIFT:  raddr = TIdxW'(ptr_q - 2'd2);
      S_FETCH:  raddr = TIdxW'(ptr_q - 1'b1);
      S_TRIM:   raddr = TIdxW'(ptr_q - 2'd2);
      S_DR_ZERO: begin
        emit  = out_free && (ptr_q < scnt_q) && (rd_q.etime == '0);
        raddr = emit ? TIdxW'(ptr_q + 1'b1) : ptr_q[TIdxW-1:0];
      end
      S_DR_COLD: emit = out_free && (cptr_q < ccnt_q);
      S_DR_REST: begin
        emit  = out_free && ((ptr_q < scnt_q) || !emitted_q);
        raddr = (out_free && (ptr_q < scnt_q)) ? TIdxW'(ptr_q + 1'b1)
                                               : ptr_q[TIdxW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready && !s_axis_tuser &&
        (mat_q != '0) && (in_t < mat_q) && (ccnt_q < CCntW'(COLD_DEPTH))) begin
      cb_q[ccnt_q[CIdxW-1:0]] <= in_b;
      ch_q[ccnt_q[CIdxW-1:0]] <= s_axis_tdata[31:0];
    end
    if (state_q == S_SHIFT) begin
      if (ptr_q == pos_q) tab_q[ptr_q[TIdxW-1:0]] <= new_q;
      else                tab_q[ptr_q[TIdxW-1:0]] <= rd_q;
    end
    rd_q <= tab_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= CountW'(1); mat_q <= '0;
      acc_q <= '0; tot_q <= '0; ovf_q <= 1'b0;
      scnt_q <= '0; ccnt_q <= '0; ptr_q <= '0; cptr_q <= '0; pos_q <= '0;
      emitted_q <= 1'b0;
      m_axis_tvalid <= 1'b0; m_axis_tlast <= 1'b0; m_axis_tdata <= '0;
      new_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegBlocksRequired) req_q <= cfg_data_i;
        else                                mat_q <= cfg_data_i[TimeW-1:0];
      end
      if (emit)               m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser) begin
            ptr_q <= '0; cptr_q <= '0; emitted_q <= 1'b0;
            state_q <= S_DR_ZERO;
          end else begin
            tot_q <= sat_add(tot_q, in_b);
            new_q <= '{etime: in_t, blocks: in_b, handle: s_axis_tdata[31:0]};
            if ((mat_q != '0) && (in_t < mat_q)) begin
              if (ccnt_q < CCntW'(COLD_DEPTH)) begin
                ccnt_q <= ccnt_q + 1'b1;
                acc_q <= sat_add(acc_q, in_b);
              end else ovf_q <= 1'b1;
            end else state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          // rd_q is the newest table entry here.
          if ((acc_q < req_q) || (scnt_q != '0 && new_q.etime < rd_q.etime)) begin
            ptr_q <= '0;
            acc_q <= sat_add(acc_q, new_q.blocks);
            state_q <= S_SEARCH;
          end else state_q <= S_IDLE;
        end
        S_SEARCH: begin
          if (search_go) ptr_q <= ptr_q + 1'b1;
          else begin
            pos_q <= ptr_q;
            ptr_q <= scnt_q;
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // Moves entries up from the top, writing the new one at its slot.
          if (ptr_q == pos_q) begin
            scnt_q <= scnt_q + 1'b1;
            ptr_q <= scnt_q + 1'b1;
            state_q <= S_FETCH;
          end else ptr_q <= ptr_q - 1'b1;
        end
        S_FETCH: state_q <= S_TRIM;
        S_TRIM: begin
          // ptr_q equals the count; rd_q is the newest entry.
          if (trim_go) begin
            acc_q <= acc_q - rd_blk;
            ptr_q <= ptr_q - 1'b1;
          end else if (ptr_q > SCntW'(TABLE_DEPTH)) begin
            acc_q <= (acc_q >= rd_blk) ? acc_q - rd_blk : '0;
            ovf_q <= 1'b1;
            scnt_q <= ptr_q - 1'b1;
            state_q <= S_IDLE;
          end else begin
            scnt_q <= ptr_q;
            state_q <= S_IDLE;
          end
        end
        S_DR_ZERO: begin
          if (emit) begin
            m_axis_tdata <= {5'b0, ovf_q, tot_q, acc_q, 1'b0, rd_q.blocks,
                             rd_q.etime, rd_q.handle, 1'b1};
            m_axis_tlast <= (ptr_q + 1'b1 == scnt_q) && ccnt_q == '0;
            emitted_q <= 1'b1;
            ptr_q <= ptr_q + 1'b1;
          end else if (out_free) state_q <= S_DR_COLD;
        end
        S_DR_COLD: begin
          if (emit) begin
            m_axis_tdata <= {5'b0, ovf_q, tot_q, acc_q, 1'b1,
                             cb_q[cptr_q[CIdxW-1:0]], {TimeW{1'b0}},
                             ch_q[cptr_q[CIdxW-1:0]], 1'b1};
            m_axis_tlast <= (cptr_q + 1'b1 == ccnt_q) && ptr_q == scnt_q;
            emitted_q <= 1'b1;
            cptr_q <= cptr_q + 1'b1;
          end else if (out_free) state_q <= S_DR_REST;
        end
        S_DR_REST: if (out_free) begin
          if (ptr_q < scnt_q) begin
            m_axis_tdata <= {5'b0, ovf_q, tot_q, acc_q, 1'b0, rd_q.blocks,
                             rd_q.etime, rd_q.handle, 1'b1};
            m_axis_tlast <= (ptr_q + 1'b1 == scnt_q);
            emitted_q <= 1'b1;
            ptr_q <= ptr_q + 1'b1;
          end else begin
            if (!emitted_q) begin
              m_axis_tdata <= {5'b0, ovf_q, tot_q, acc_q, 105'b0, 1'b0};
              m_axis_tlast <= 1'b1;
            end
            scnt_q <= '0; ccnt_q <= '0; acc_q <= '0; tot_q <= '0; ovf_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcs_checker.sv =====
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the purge candidate selector.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [207:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);

  // A pending result blocks new input.
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("result changed under stall");

  // An empty result is always the last one.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast)
    else $error("empty result not last");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[207:203] == 5'b0) else $error("pad bits set");

endmodule

bind purge_candidate_selector_core pcs_checker u_pcs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// ===== dv/purge_candidate_selector_core_tb.sv =====
// ----------------------------------------------------------------------------
// purge_candidate_selector_core_tb
// Self-checking bench for the purge candidate selector. Check and drain
// transactions are driven with random gaps, the sorted table and cold list
// are predicted in the bench, and every drained entry is compared field by
// field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module purge_candidate_selector_core_tb;
  import pcs_pkg::*;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned ColdDepth  = 32;
  localparam logic KindCheck = 1'b0;
  localparam logic KindDrain = 1'b1;
  localparam logic [47:0] Mask48 = {48{1'b1}};

  typedef struct packed {
    logic        kind;
    logic [31:0] handle;
    logic [31:0] atime;
    logic [39:0] blocks;
  } file_item_t;

  typedef struct packed {
    logic        ovf;
    logic [47:0] total;
    logic [47:0] acc;
    logic        last;
    logic        cold;
    logic [39:0] blocks;
    logic [31:0] etime;
    logic [31:0] handle;
    logic        valid;
  } candidate_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [47:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic         m_axis_tlast;

  purge_candidate_selector_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #6 clk_i = ~clk_i;

  // Predicted selector state.
  logic [47:0] p_required = 48'd1;
  logic [31:0] p_min_time = '0;
  logic [31:0] st_time [TableDepth+1];
  logic [39:0] st_size [TableDepth+1];
  logic [31:0] st_handle [TableDepth+1];
  int unsigned st_count = 0;
  logic [39:0] cl_blocks [ColdDepth];
  logic [31:0] cl_handle [ColdDepth];
  int unsigned cl_count = 0;
  logic [47:0] p_acc = '0;
  logic [47:0] p_total = '0;
  logic        p_ovf = 1'b0;

  file_item_t  pending_items[$];
  candidate_t  expected_candidates[$];
  int unsigned mismatch_count = 0;
  int unsigned drains_done = 0;
  int unsigned entries_seen = 0;
  int unsigned checks_sent = 0;
  bit          long_stall_req = 1'b0;
  bit          stall_taken = 1'b0;
  int unsigned stall_left = 0;
  int unsigned s_gap = 0;
  int unsigned m_gap = 0;
  logic        s_fire_q = 1'b0;

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [39:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[48] ? Mask48 : s[47:0];
  endfunction

  function automatic void drop_newest_entry();
    logic [39:0] b;
    b = st_size[st_count-1];
    p_acc = (p_acc >= {8'd0, b}) ? p_acc - {8'd0, b} : '0;
    st_count--;
  endfunction

  function automatic void select_file(file_item_t it);
    int unsigned pos;
    logic [39:0] b;
    p_total = add_sat(p_total, it.blocks);
    if (p_min_time != 0 && it.atime < p_min_time) begin
      if (cl_count < ColdDepth) begin
        cl_handle[cl_count] = it.handle;
        cl_blocks[cl_count] = it.blocks;
        cl_count++;
        p_acc = add_sat(p_acc, it.blocks);
      end else begin
        p_ovf = 1'b1;
      end
      return;
    end
    if (!(p_acc < p_required || (st_count > 0 && it.atime < st_time[st_count-1])))
      return;
    pos = 0;
    while (pos < st_count && st_time[pos] <= it.atime) pos++;
    for (int unsigned i = st_count; i > pos; i--) begin
      st_time[i] = st_time[i-1];
      st_size[i] = st_size[i-1];
      st_handle[i] = st_handle[i-1];
    end
    st_time[pos] = it.atime;
    st_size[pos] = it.blocks;
    st_handle[pos] = it.handle;
    st_count++;
    p_acc = add_sat(p_acc, it.blocks);
    while (st_count > 0) begin
      b = st_size[st_count-1];
      if (p_acc >= {8'd0, b} && p_acc - {8'd0, b} >= p_required) drop_newest_entry();
      else break;
    end
    if (st_count > TableDepth) begin
      drop_newest_entry();
      p_ovf = 1'b1;
    end
  endfunction

  function automatic void push_candidate(logic v, logic [31:0] h, logic [31:0] t,
                                         logic [39:0] b, logic c);
    candidate_t r;
    r = '{ovf: p_ovf, total: p_total, acc: p_acc, last: 1'b0, cold: c,
          blocks: b, etime: t, handle: h, valid: v};
    expected_candidates.insert(expected_candidates.size(), r);
  endfunction

  function automatic void drain_candidates();
    int unsigned i;
    int unsigned n0;
    n0 = expected_candidates.size();
    i = 0;
    while (i < st_count && st_time[i] == 0) begin
      push_candidate(1'b1, st_handle[i], '0, st_size[i], 1'b0);
      i++;
    end
    for (int unsigned c = 0; c < cl_count; c++)
      push_candidate(1'b1, cl_handle[c], '0, cl_blocks[c], 1'b1);
    for (; i < st_count; i++)
      push_candidate(1'b1, st_handle[i], st_time[i], st_size[i], 1'b0);
    if (expected_candidates.size() == n0) push_candidate(1'b0, '0, '0, '0, 1'b0);
    expected_candidates[expected_candidates.size()-1].last = 1'b1;
    st_count = 0;
    cl_count = 0;
    p_acc = '0;
    p_total = '0;
    p_ovf = 1'b0;
  endfunction

  function automatic void queue_item(file_item_t it);
    pending_items.insert(pending_items.size(), it);
    checks_sent++;
  endfunction

  task automatic report_mismatch(string what, logic [207:0] got, logic [207:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Acceptance is checked at the falling edge from signals held since the rising one.
  always @(posedge clk_i) s_fire_q <= s_axis_tvalid && s_axis_tready;

  // Driver: offers pending items with random gaps; prediction at acceptance.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_fire_q) begin
        if (pending_items[0].kind == KindDrain) drain_candidates();
        else select_file(pending_items[0]);
        void'(pending_items.pop_front());
        s_gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) s_gap = 0;
      end
      if (s_gap > 0) begin
        s_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_items[0].kind;
        s_axis_tdata  <= {pending_items[0].blocks, pending_items[0].atime,
                          pending_items[0].handle};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern; a requested long stall is counted here.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (m_gap > 0) begin
        m_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        m_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    candidate_t got;
    candidate_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{ovf: m_axis_tdata[202], total: m_axis_tdata[201:154],
              acc: m_axis_tdata[153:106], last: m_axis_tlast,
              cold: m_axis_tdata[105], blocks: m_axis_tdata[104:65],
              etime: m_axis_tdata[64:33], handle: m_axis_tdata[32:1],
              valid: m_axis_tdata[0]};
      entries_seen++;
      if (expected_candidates.size() == 0) begin
        report_mismatch("unexpected result", 208'(got), '0);
      end else begin
        want = expected_candidates.pop_front();
        if (got.valid !== want.valid)
          report_mismatch("entry_valid", 208'(got.valid), 208'(want.valid));
        if (got.handle !== want.handle)
          report_mismatch("entry_handle", 208'(got.handle), 208'(want.handle));
        if (got.etime !== want.etime)
          report_mismatch("entry_time", 208'(got.etime), 208'(want.etime));
        if (got.blocks !== want.blocks)
          report_mismatch("entry_blocks", 208'(got.blocks), 208'(want.blocks));
        if (got.cold !== want.cold)
          report_mismatch("is_cold", 208'(got.cold), 208'(want.cold));
        if (got.last !== want.last)
          report_mismatch("tlast", 208'(got.last), 208'(want.last));
        if (got.acc !== want.acc)
          report_mismatch("accumulated_blocks", 208'(got.acc), 208'(want.acc));
        if (got.total !== want.total)
          report_mismatch("total_blocks", 208'(got.total), 208'(want.total));
        if (got.ovf !== want.ovf)
          report_mismatch("overflow", 208'(got.ovf), 208'(want.ovf));
        if (m_axis_tdata[207:203] !== '0) report_mismatch("pad bits", m_axis_tdata, '0);
      end
    end
  end

  function automatic file_item_t check_item(logic [31:0] h, logic [31:0] t, logic [39:0] b);
    return '{kind: KindCheck, handle: h, atime: t, blocks: b};
  endfunction

  function automatic file_item_t drain_item();
    file_item_t it;
    it = '{kind: KindDrain, handle: $urandom, atime: $urandom,
           blocks: {8'($urandom_range(0, 255)), $urandom}};
    return it;
  endfunction

  function automatic logic [39:0] rand_blocks();
    case ($urandom_range(0, 5))
      0: return {8'($urandom_range(0, 255)), $urandom};
      1: return 40'hFF_FFFF_FFFF;
      default: return 40'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_candidates.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegBlocksRequired) p_required = val;
    else p_min_time = val[31:0];
  endtask

  // One phase: a burst of checks with the odd drain among them, then a drain. Small time ranges give ties.
  task automatic random_phase(int unsigned n, int unsigned trange);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) queue_item(drain_item());
      else queue_item(check_item($urandom,
             (trange == 0) ? $urandom : $urandom_range(0, trange), rand_blocks()));
    end
    queue_item(drain_item());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty drain, time zero, ties, field extremes.
    queue_item(drain_item());
    queue_item(check_item('1, '1, 40'hFF_FFFF_FFFF));
    queue_item(check_item('0, '0, '0));
    queue_item(check_item(32'h5555_5555, 32'd0, 40'd3));
    queue_item(drain_item());
    queue_item(check_item(32'hAAAA_AAAA, 32'd7, 40'd0));
    queue_item(check_item(32'h1234_5678, 32'd7, 40'd0));
    queue_item(check_item(32'h0F0F_0F0F, 32'd3, 40'd0));
    queue_item(drain_item());
    wait_idle();

    // Cold list filling up and overflowing.
    write_reg(RegBlocksRequired, Mask48);
    write_reg(RegMinAccessTime, 48'hFFFF_FFFF);
    queue_item(check_item(32'd1, 32'd0, 40'd5));
    for (int i = 0; i < 40; i++)
      queue_item(check_item($urandom, $urandom_range(1, 100), 40'hFF_FFFF_FFFF));
    queue_item(drain_item());
    // These wait behind the drain while the receiver holds off.
    for (int i = 0; i < 3; i++)
      queue_item(check_item($urandom, $urandom_range(1, 100), rand_blocks()));
    while (pending_items.size() > 3) @(posedge clk_i);
    long_stall_req = 1'b1;
    wait (stall_taken && stall_left == 0);
    wait_idle();

    // Sorted table overflow: huge requirement, no cold list.
    write_reg(RegMinAccessTime, 48'd0);
    random_phase(45, 0);
    wait_idle();

    // Mid-range settings with trimming and mixed cold entries.
    write_reg(RegBlocksRequired, 48'd400);
    write_reg(RegMinAccessTime, 48'd20);
    random_phase(60, 60);
    wait_idle();

    write_reg(RegBlocksRequired, 48'd0);
    write_reg(RegMinAccessTime, 48'd1);
    random_phase(20, 4);
    wait_idle();

    write_reg(RegBlocksRequired, 48'd1);
    write_reg(RegMinAccessTime, 48'd0);
    random_phase(30, 0);
    wait_idle();

    write_reg(RegBlocksRequired, 48'({$urandom, $urandom}));
    write_reg(RegMinAccessTime, 48'h8000_0000);
    random_phase(40, 0);
    wait_idle();

    $display("Covered %0d input transactions and %0d drained candidate results.",
             checks_sent, entries_seen);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
